// ----- hdl/pcn_pkg.sv -----
package pcn_pkg;

  // Width of a linear cell index on the input side.
  localparam int IDX_W = 15;

  // Width of the grid side register as written through the configuration port.
  localparam int CFG_W = 6;

  // Grid side after reset, before any clamping to the configured maximum.
  localparam int GRID_SIDE_RST = 8;

  // Restoring division steps done between two pipeline registers.
  localparam int STEPS_PER_STAGE = 3;

  typedef logic [IDX_W-1:0] cell_idx_t;

  // Range status of one query, produced by the front end.
  typedef struct packed {
    logic home_ok;
    logic probe_ok;
  } cell_flags_t;

endpackage

// ----- hdl/periodic_cell_neighbor_test.sv -----
// Periodic cell neighbor test.
//
// Each query names a home cell and a probe cell by linear index in a cube of
// side^3 cells that wraps on every axis. The result tells whether the probe
// is one of the 26 wrapped neighbors of the home cell, and flags a home index
// outside the cube (the neighbor bit is then zero).
//
// Input side: a query transfers when push is high and full is low. Result
// side: the oldest result sits on the out_ ports while empty is low and
// transfers when pop is high. One query is taken every cycle while full is
// low; each result passes through the ten-stage division pipeline (three
// restoring steps per stage), the queue and the output register.
//
// When the receiver stalls, results collect in a 16-entry queue; full rises
// once the pipeline and queue together hold 16 queries, and drops as soon as
// one leaves the queue. Reset empties the block and sets the side to 8. The
// side may only be rewritten while no query is in flight.
module periodic_cell_neighbor_test #(
  parameter int MAX_SIDE = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  output logic                       full,
  input  logic [pcn_pkg::IDX_W-1:0]  in_home_cell,
  input  logic [pcn_pkg::IDX_W-1:0]  in_probe_cell,
  output logic                       empty,
  input  logic                       pop,
  output logic                       out_is_neighbor,
  output logic                       out_index_error,
  input  logic                       cfg_wr_en,
  input  logic [pcn_pkg::CFG_W-1:0]  cfg_grid_side
);

  localparam int RW       = $clog2(MAX_SIDE + 1);
  localparam int TOT      = 2 * pcn_pkg::IDX_W;
  localparam int NSTG     = (TOT + pcn_pkg::STEPS_PER_STAGE - 1) / pcn_pkg::STEPS_PER_STAGE;
  localparam int FDEPTH   = 1 << $clog2(NSTG + 2);
  localparam int CRD_W    = 6 * RW;
  localparam int EW       = $bits(pcn_pkg::cell_flags_t) + CRD_W;
  localparam int SIDE_RST = (pcn_pkg::GRID_SIDE_RST > MAX_SIDE) ? MAX_SIDE
                                                                 : pcn_pkg::GRID_SIDE_RST;

  logic [RW-1:0]         side_r;
  logic [RW-1:0]         side_nxt;

  logic                  wr_valid;
  pcn_pkg::cell_flags_t  wr_flags;
  logic [CRD_W-1:0]      wr_coords;

  logic                  q_pop;
  logic                  q_empty;
  logic [EW-1:0]         q_data;
  pcn_pkg::cell_flags_t  q_flags;
  logic [CRD_W-1:0]      q_coords;

  // The side is kept already clamped: zero acts as one and anything above
  // the maximum acts as the maximum.
  always_comb begin
    side_nxt = side_r;
    if (cfg_wr_en) begin
      if (cfg_grid_side == '0) begin
        side_nxt = RW'(1);
      end else if (int'(cfg_grid_side) > MAX_SIDE) begin
        side_nxt = RW'(MAX_SIDE);
      end else begin
        side_nxt = RW'(cfg_grid_side);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r <= RW'(SIDE_RST);
    end else begin
      side_r <= side_nxt;
    end
  end

  // Front end: takes queries and splits both indices into coordinates.
  pcn_front #(
    .MAX_SIDE (MAX_SIDE),
    .FDEPTH   (FDEPTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .home_cell  (in_home_cell),
    .probe_cell (in_probe_cell),
    .side       (side_r),
    .q_pop      (q_pop),
    .wr_valid   (wr_valid),
    .wr_flags   (wr_flags),
    .wr_coords  (wr_coords)
  );

  pcn_fifo #(
    .W     (EW),
    .DEPTH (FDEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_valid),
    .wr_data ({wr_flags, wr_coords}),
    .rd_en   (q_pop),
    .empty   (q_empty),
    .rd_data (q_data)
  );

  assign {q_flags, q_coords} = q_data;

  // Back end: compares coordinates per axis and holds the result.
  pcn_back #(
    .MAX_SIDE (MAX_SIDE)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .side        (side_r),
    .q_empty     (q_empty),
    .q_flags     (q_flags),
    .q_coords    (q_coords),
    .q_pop       (q_pop),
    .empty       (empty),
    .pop         (pop),
    .is_neighbor (out_is_neighbor),
    .index_error (out_index_error)
  );

endmodule

// ----- hdl/pcn_front.sv -----
module pcn_front #(
  parameter int MAX_SIDE = 32,
  parameter int FDEPTH   = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push,
  output logic                                full,
  input  pcn_pkg::cell_idx_t                  home_cell,
  input  pcn_pkg::cell_idx_t                  probe_cell,
  input  logic [$clog2(MAX_SIDE+1)-1:0]       side,
  input  logic                                q_pop,
  output logic                                wr_valid,
  output pcn_pkg::cell_flags_t                wr_flags,
  output logic [6*$clog2(MAX_SIDE+1)-1:0]     wr_coords
);

  localparam int RW    = $clog2(MAX_SIDE + 1);
  localparam int IW    = pcn_pkg::IDX_W;
  localparam int BPS   = pcn_pkg::STEPS_PER_STAGE;
  localparam int TOT   = 2 * IW;
  localparam int NSTG  = (TOT + BPS - 1) / BPS;
  localparam int CNT_W = $clog2(FDEPTH + 1);

  logic                accept;
  logic [CNT_W-1:0]    cnt_r;
  logic [CNT_W-1:0]    cnt_nxt;

  logic                vld_r [0:NSTG];
  logic [RW-1:0]       rem_r [0:NSTG][0:1];
  logic [IW-1:0]       dq_r  [0:NSTG][0:1];
  logic [RW-1:0]       col_r [0:NSTG][0:1];

  assign accept = push & ~full;

  // Items in the split pipeline plus items in the queue never exceed the
  // queue depth, so the pipeline never has to stall.
  assign full = (cnt_r == CNT_W'(FDEPTH));

  always_comb begin
    cnt_nxt = cnt_r;
    if (accept && !q_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (!accept && q_pop) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      vld_r[0] <= 1'b0;
    end else begin
      cnt_r    <= cnt_nxt;
      vld_r[0] <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rem_r[0][0] <= '0;
      rem_r[0][1] <= '0;
      dq_r[0][0]  <= home_cell;
      dq_r[0][1]  <= probe_cell;
      col_r[0][0] <= '0;
      col_r[0][1] <= '0;
    end
  end

  // Each stage runs a few steps of two chained divisions by the side:
  // index / side gives the column as remainder, and the quotient divided by
  // the side again gives the row as remainder and the layer as quotient.
  for (genvar k = 0; k < NSTG; k++) begin : g_stage
    logic [RW-1:0] rem_nxt [0:1];
    logic [IW-1:0] dq_nxt  [0:1];
    logic [RW-1:0] col_nxt [0:1];

    always_comb begin
      logic [RW:0] t;
      t = '0;
      for (int o = 0; o < 2; o++) begin
        rem_nxt[o] = rem_r[k][o];
        dq_nxt[o]  = dq_r[k][o];
        col_nxt[o] = col_r[k][o];
        for (int j = 0; j < BPS; j++) begin
          if (k * BPS + j == IW) begin
            col_nxt[o] = rem_nxt[o];
            rem_nxt[o] = '0;
          end
          if (k * BPS + j < TOT) begin
            t         = {rem_nxt[o], dq_nxt[o][IW-1]};
            dq_nxt[o] = {dq_nxt[o][IW-2:0], 1'b0};
            if (t >= {1'b0, side}) begin
              rem_nxt[o]   = RW'(t - {1'b0, side});
              dq_nxt[o][0] = 1'b1;
            end else begin
              rem_nxt[o] = t[RW-1:0];
            end
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      for (int o = 0; o < 2; o++) begin
        rem_r[k+1][o] <= rem_nxt[o];
        dq_r[k+1][o]  <= dq_nxt[o];
        col_r[k+1][o] <= col_nxt[o];
      end
    end
  end

  // A layer quotient below the side means the index lies inside the cube.
  assign wr_valid          = vld_r[NSTG];
  assign wr_flags.home_ok  = (dq_r[NSTG][0] < IW'(side));
  assign wr_flags.probe_ok = (dq_r[NSTG][1] < IW'(side));
  assign wr_coords = {dq_r[NSTG][0][RW-1:0], rem_r[NSTG][0], col_r[NSTG][0],
                      dq_r[NSTG][1][RW-1:0], rem_r[NSTG][1], col_r[NSTG][1]};

endmodule

// ----- hdl/pcn_fifo.sv -----
module pcn_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_en,
  input  logic [W-1:0] wr_data,
  input  logic         rd_en,
  output logic         empty,
  output logic [W-1:0] rd_data
);

  localparam int AW = $clog2(DEPTH);

  logic [W-1:0] mem [0:DEPTH-1];
  logic [AW:0]  wr_ptr_r;
  logic [AW:0]  rd_ptr_r;
  logic [AW:0]  rd_ptr_nxt;
  logic [W-1:0] rd_data_r;

  assign empty      = (wr_ptr_r == rd_ptr_r);
  assign rd_ptr_nxt = rd_en ? rd_ptr_r + (AW+1)'(1) : rd_ptr_r;
  assign rd_data    = rd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= wr_ptr_r + (AW+1)'(1);
      end
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr_r[AW-1:0]] <= wr_data;
    end
  end

  // The head entry is fetched ahead into a register. An entry written at
  // the same edge as it becomes the head is taken straight from the write.
  always_ff @(posedge clk) begin
    if (wr_en && (wr_ptr_r[AW-1:0] == rd_ptr_nxt[AW-1:0])) begin
      rd_data_r <= wr_data;
    end else begin
      rd_data_r <= mem[rd_ptr_nxt[AW-1:0]];
    end
  end

endmodule

// ----- hdl/pcn_back.sv -----
module pcn_back #(
  parameter int MAX_SIDE = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [$clog2(MAX_SIDE+1)-1:0]       side,
  input  logic                                q_empty,
  input  pcn_pkg::cell_flags_t                q_flags,
  input  logic [6*$clog2(MAX_SIDE+1)-1:0]     q_coords,
  output logic                                q_pop,
  output logic                                empty,
  input  logic                                pop,
  output logic                                is_neighbor,
  output logic                                index_error
);

  localparam int RW = $clog2(MAX_SIDE + 1);

  logic          out_vld_r;
  logic          out_vld_nxt;
  logic          nb_r;
  logic          err_r;
  logic          nb_nxt;
  logic [1:0]    ax_l;
  logic [1:0]    ax_r;
  logic [1:0]    ax_c;
  logic [RW-1:0] hl, hr, hc, pl, pr, pc;

  // Returns {close, same} for one axis: the wrapped difference is 0, 1 or
  // side-1, and whether it is 0.
  function automatic logic [1:0] axis_test(input logic [RW-1:0] p,
                                           input logic [RW-1:0] h,
                                           input logic [RW-1:0] s);
    logic [RW:0] d;
    logic        close;
    logic        same;
    if (p >= h) begin
      d = {1'b0, p} - {1'b0, h};
    end else begin
      d = {1'b0, p} + {1'b0, s} - {1'b0, h};
    end
    same  = (d == '0);
    close = same || (d == (RW+1)'(1)) || (d == ({1'b0, s} - (RW+1)'(1)));
    return {close, same};
  endfunction

  assign {hl, hr, hc, pl, pr, pc} = q_coords;

  assign ax_l = axis_test(pl, hl, side);
  assign ax_r = axis_test(pr, hr, side);
  assign ax_c = axis_test(pc, hc, side);

  always_comb begin
    nb_nxt = 1'b0;
    if (q_flags.home_ok && q_flags.probe_ok) begin
      if (side == RW'(1)) begin
        nb_nxt = 1'b1;
      end else begin
        nb_nxt = ax_l[1] & ax_r[1] & ax_c[1] & ~(ax_l[0] & ax_r[0] & ax_c[0]);
      end
    end
  end

  assign q_pop = ~q_empty & (~out_vld_r | pop);

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (q_pop) begin
      out_vld_nxt = 1'b1;
    end else if (pop) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      nb_r  <= nb_nxt;
      err_r <= ~q_flags.home_ok;
    end
  end

  assign empty       = ~out_vld_r;
  assign is_neighbor = nb_r;
  assign index_error = err_r;

endmodule

// ----- hdl/pcn_checker.sv -----
module pcn_checker (
  input logic clk,
  input logic rst_n,
  input logic push,
  input logic full,
  input logic empty,
  input logic pop,
  input logic out_is_neighbor,
  input logic out_index_error
);

  // Reset leaves nothing to deliver.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result waiting right after reset");

  // Reset leaves room for a query.
  a_reset_not_full: assert property (@(posedge clk) !rst_n |=> !full)
    else $error("input full right after reset");

  // A home cell outside the grid never reports a neighbor.
  a_err_no_nb: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_index_error |-> !out_is_neighbor)
    else $error("neighbor reported with index error");

  // A waiting result holds until it transfers.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_is_neighbor) && $stable(out_index_error))
    else $error("waiting result changed or vanished");

endmodule

bind periodic_cell_neighbor_test pcn_checker u_pcn_checker (.*);

// ----- test/tb_periodic_cell_neighbor_test.sv -----
`timescale 1ns / 1ps

module tb_periodic_cell_neighbor_test;

  // The block is built with its default maximum side.
  localparam int MAX_SIDE = 32;

  // Longest run of cycles without any transfer before the run is declared hung.
  // It covers the long receiver hold-off, the idle time around register writes
  // and the longest random gaps on both sides, several times over.
  localparam int WATCHDOG_LIMIT = 4000;

  // Cycles the receiver refuses results during the back-pressure test. This
  // is far longer than it takes the 16-entry pipeline and queue to fill.
  localparam int HOLD_CYCLES = 300;

  // Extra cycles allowed after the last expected result before a register
  // write or the end of the run.
  localparam int SETTLE_CYCLES = 24;

  // Number of mismatches printed in full; later ones are only counted.
  localparam int REPORT_LIMIT = 10;

  // One expected or observed neighbor query answer.
  typedef struct packed {
    logic is_neighbor;
    logic index_error;
  } query_result_t;

  logic                      clk;
  logic                      rst_n;
  logic                      push;
  logic                      full;
  pcn_pkg::cell_idx_t        in_home_cell;
  pcn_pkg::cell_idx_t        in_probe_cell;
  logic                      empty;
  logic                      pop;
  logic                      out_is_neighbor;
  logic                      out_index_error;
  logic                      cfg_wr_en;
  logic [pcn_pkg::CFG_W-1:0] cfg_grid_side;

  // The testbench's own copy of the grid side register.
  logic [pcn_pkg::CFG_W-1:0] grid_side_model;

  // Answers predicted for accepted queries, oldest first.
  query_result_t    pending_answers[$];

  int               failures;
  int               mismatches;
  int               stall_cycles;

  // Idling controls: each side may insert random gaps before every transfer.
  bit               tx_idle_on;
  bit               rx_idle_on;

  // A request for a long receiver hold-off, and the hold-off itself.
  bit               hold_request;
  bit               rx_hold;

  periodic_cell_neighbor_test #(
    .MAX_SIDE(MAX_SIDE)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_home_cell   (in_home_cell),
    .in_probe_cell  (in_probe_cell),
    .empty          (empty),
    .pop            (pop),
    .out_is_neighbor(out_is_neighbor),
    .out_index_error(out_index_error),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_grid_side  (cfg_grid_side)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // The side the block actually uses: zero acts as one, and anything above
  // the maximum is clamped to the maximum.
  function automatic int unsigned side_in_use(logic [pcn_pkg::CFG_W-1:0] side_reg);
    int unsigned s;
    s = 32'(side_reg);
    if (s == 0) s = 1;
    if (s > MAX_SIDE) s = MAX_SIDE;
    return s;
  endfunction

  // True when the wrapped distance from h to p along one axis is at most one.
  function automatic bit axis_within_one(int unsigned p, int unsigned h, int unsigned s);
    int unsigned d;
    d = (p + s - h) % s;
    return (d == 0) || (d == 1) || (d == s - 1);
  endfunction

  // Computes the answer for one query under the given side register value.
  function automatic query_result_t predict_neighbor(pcn_pkg::cell_idx_t home,
                                                     pcn_pkg::cell_idx_t probe,
                                                     logic [pcn_pkg::CFG_W-1:0] side_reg);
    int unsigned   s;
    int unsigned   surf;
    int unsigned   cells;
    int unsigned   h;
    int unsigned   p;
    query_result_t r;
    s     = side_in_use(side_reg);
    surf  = s * s;
    cells = surf * s;
    h     = 32'(home);
    p     = 32'(probe);
    r     = '0;
    if (h >= cells) begin
      r.index_error = 1'b1;
    end else if (p < cells) begin
      if (s == 1) begin
        // In a one-cell grid every offset lands on the home cell itself.
        r.is_neighbor = 1'b1;
      end else begin
        // Both indexes lie inside the grid, so equal coordinates on all three
        // axes means the same index.
        r.is_neighbor = axis_within_one(p / surf, h / surf, s) &&
                        axis_within_one((p % surf) / s, (h % surf) / s, s) &&
                        axis_within_one(p % s, h % s, s) &&
                        (p != h);
      end
    end
    return r;
  endfunction

  // Returns a cell reached from home by a random offset in {-1,0,1} on each
  // axis, wrapped. The zero offset is included, so the home cell comes back too.
  function automatic int unsigned wrapped_offset_cell(int unsigned home, int unsigned s);
    int unsigned lay;
    int unsigned row;
    int unsigned col;
    lay = home / (s * s);
    row = (home % (s * s)) / s;
    col = home % s;
    lay = (lay + s + $urandom_range(0, 2) - 1) % s;
    row = (row + s + $urandom_range(0, 2) - 1) % s;
    col = (col + s + $urandom_range(0, 2) - 1) % s;
    return lay * s * s + row * s + col;
  endfunction

  // Offers one query after a random gap and waits for its transfer. The
  // expected answer is queued at the clock edge where the transfer happens.
  task automatic send_query(pcn_pkg::cell_idx_t home, pcn_pkg::cell_idx_t probe);
    int unsigned gap;
    gap = tx_idle_on ? $urandom_range(0, 14) : 0;
    repeat (gap) begin
      @(negedge clk);
      push <= 1'b0;
    end
    @(negedge clk);
    push          <= 1'b1;
    in_home_cell  <= home;
    in_probe_cell <= probe;
    @(posedge clk);
    while (full) @(posedge clk);
    pending_answers.push_back(predict_neighbor(home, probe, grid_side_model));
  endtask

  // Draws a query under the current side. Most queries are in-grid homes with
  // a probe at most one step away, so the per-axis wrap logic is exercised; the rest
  // are random in-grid probes and random indexes over the whole field range.
  task automatic send_random_query();
    int unsigned s;
    int unsigned cells;
    int unsigned kind;
    int unsigned h;
    int unsigned p;
    s     = side_in_use(grid_side_model);
    cells = s * s * s;
    kind  = $urandom_range(0, 9);
    h     = $urandom_range(0, cells - 1);
    if (kind < 6) begin
      p = wrapped_offset_cell(h, s);
    end else if (kind < 8) begin
      p = $urandom_range(0, cells - 1);
    end else if (kind == 8) begin
      p = $urandom_range(0, 32767);
    end else begin
      h = $urandom_range(0, 32767);
      p = $urandom_range(0, 32767);
    end
    send_query(h[pcn_pkg::IDX_W-1:0], p[pcn_pkg::IDX_W-1:0]);
  endtask

  // Stops offering queries, waits for every expected answer and then lets the
  // pipeline settle, so nothing is in flight.
  task automatic wait_idle();
    @(negedge clk);
    push <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Rewrites the grid side once the block is idle.
  task automatic write_grid_side(logic [pcn_pkg::CFG_W-1:0] side_reg);
    wait_idle();
    @(negedge clk);
    cfg_wr_en     <= 1'b1;
    cfg_grid_side <= side_reg;
    @(negedge clk);
    cfg_wr_en       <= 1'b0;
    grid_side_model  = side_reg;
  endtask

  // Queries under the side set by reset, before any register write: self,
  // plain steps, wrap on the column axis and on all three, cells two steps
  // away, homes outside the grid and probes outside the grid.
  task automatic test_reset_side();
    send_query(15'd0, 15'd0);
    send_query(15'd0, 15'd1);
    send_query(15'd0, 15'd2);
    send_query(15'd0, 15'd7);
    send_query(15'd0, 15'd64);
    send_query(15'd0, 15'd73);
    send_query(15'd0, 15'd128);
    send_query(15'd0, 15'd511);
    send_query(15'd511, 15'd0);
    send_query(15'd512, 15'd0);
    send_query(15'd32767, 15'd32767);
    send_query(15'd0, 15'd32767);
    send_query(15'd100, 15'd512);
  endtask

  // Side extremes: a one-cell grid, a zero side that acts as one, the side
  // where every other cell is a neighbor, the largest side, and sides above
  // the maximum that must be clamped.
  task automatic test_side_extremes();
    write_grid_side(6'd1);
    send_query(15'd0, 15'd0);
    send_query(15'd0, 15'd1);
    send_query(15'd1, 15'd0);
    write_grid_side(6'd0);
    send_query(15'd0, 15'd0);
    send_query(15'd5, 15'd5);
    write_grid_side(6'd2);
    send_query(15'd0, 15'd7);
    send_query(15'd3, 15'd3);
    write_grid_side(6'd32);
    send_query(15'd32767, 15'd0);
    send_query(15'd0, 15'd32767);
    send_query(15'd32767, 15'd32767);
    write_grid_side(6'd63);
    send_query(15'd32767, 15'd0);
    write_grid_side(6'd33);
    send_query(15'd0, 15'd31744);
  endtask

  // Random queries under a series of sides, each phase with its own idling
  // mix so that stretches without any gaps occur as well.
  task automatic test_random_sides();
    logic [pcn_pkg::CFG_W-1:0] side_list[8];
    int unsigned               mode;
    side_list[0] = 6'd3;
    side_list[1] = 6'd32;
    side_list[2] = 6'd2;
    side_list[3] = 6'd63;
    for (int i = 4; i < 8; i++) side_list[i] = pcn_pkg::CFG_W'($urandom_range(0, 63));
    for (int ph = 0; ph < 8; ph++) begin
      write_grid_side(side_list[ph]);
      mode       = $urandom_range(0, 3);
      tx_idle_on = mode[0];
      rx_idle_on = mode[1];
      for (int n = 0; n < 100; n++) send_random_query();
    end
  endtask

  // The receiver holds off for a long stretch while queries keep coming back
  // to back, so the block fills up and must hold full until results drain.
  task automatic test_backpressure();
    write_grid_side(6'd5);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    @(negedge clk);
    hold_request = 1'b1;
    for (int n = 0; n < 40; n++) send_random_query();
    rx_idle_on = 1'b1;
    tx_idle_on = 1'b1;
  endtask

  // Main sequence: reset once, run each test in turn, drain and report.
  initial begin
    rst_n           = 1'b0;
    push            = 1'b0;
    in_home_cell    = '0;
    in_probe_cell   = '0;
    pop             = 1'b0;
    cfg_wr_en       = 1'b0;
    cfg_grid_side   = '0;
    grid_side_model = pcn_pkg::CFG_W'(pcn_pkg::GRID_SIDE_RST);
    failures        = 0;
    mismatches      = 0;
    tx_idle_on      = 1'b1;
    rx_idle_on      = 1'b1;
    hold_request    = 1'b0;
    rx_hold         = 1'b0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    test_reset_side();
    test_side_extremes();
    test_random_sides();
    test_backpressure();

    wait_idle();
    if (failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Receiver: waits a random number of cycles before each result, stays off
  // while a hold-off is running, then raises pop until a transfer happens.
  // Pop stays high across back-to-back transfers when no gap is drawn.
  initial begin : result_receiver
    int unsigned pause;
    @(posedge rst_n);
    forever begin
      pause = rx_idle_on ? $urandom_range(0, 14) : 0;
      repeat (pause) begin
        @(negedge clk);
        pop <= 1'b0;
      end
      while (rx_hold) begin
        @(negedge clk);
        pop <= 1'b0;
      end
      @(negedge clk);
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
    end
  end

  // Counts out the long receiver hold-off once it is requested.
  initial begin : hold_timer
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        rx_hold      = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold = 1'b0;
      end
    end
  end

  // Checks every result transfer against the oldest pending answer.
  always @(posedge clk) begin
    query_result_t want;
    if (rst_n && pop && !empty) begin
      if (pending_answers.size() == 0) begin
        failures++;
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result: is_neighbor=%0b index_error=%0b",
                   out_is_neighbor, out_index_error);
      end else begin
        want = pending_answers.pop_front();
        if (out_is_neighbor !== want.is_neighbor ||
            out_index_error !== want.index_error) begin
          failures++;
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("mismatch: is_neighbor exp %0b got %0b, index_error exp %0b got %0b",
                     want.is_neighbor, out_is_neighbor, want.index_error, out_index_error);
        end
      end
    end
  end

  // Watchdog: any cycle with a transfer on either side restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

endmodule
